FILE: hdl/psds_pkg.sv
// ----------------------------------------------------------------------------
// psds_pkg
// Shared constants and types of the phase-shift depth step unit.
// ----------------------------------------------------------------------------
`default_nettype none
package psds_pkg;

  localparam int FFT_SIZE        = 1024;
  localparam int BIN_BITS        = 10;
  localparam int SAMPLE_BITS     = 24;
  localparam int GUARD_BITS      = 6;
  localparam int TWO_PI_Q24      = 105414357;
  localparam int PI_Q24          = 52707179;
  localparam int HALF_PI_Q24     = 26353589;
  localparam int CORDIC_GAIN_Q24 = 10188014;
  localparam int LN2_Q24         = 11629080;
  localparam int EXP_TERMS       = 12;
  localparam int DECAY_SHIFTS    = 32;
  localparam int DECAY_NBITS     = 5;
  localparam int ONE_Q30         = 1 << 30;

  // arctangents of 2^-i at Q24
  localparam int ATAN_Q24 [32] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  typedef enum logic [1:0] {
    REG_ANG_FREQ = 2'd0,
    REG_SLOWNESS = 2'd1,
    REG_DEPTH    = 2'd2,
    REG_WAVENUM  = 2'd3
  } reg_addr_e;

  // per-word fields that ride along the pipeline
  typedef struct packed {
    logic                          kind;
    logic                          prop;
    logic                          accum;
    logic signed [SAMPLE_BITS-1:0] samp_re;
    logic signed [SAMPLE_BITS-1:0] samp_im;
    logic signed [SAMPLE_BITS-1:0] acc_re;
    logic signed [SAMPLE_BITS-1:0] acc_im;
  } side_t;

endpackage
`default_nettype wire

FILE: hdl/phase_shift_depth_step_unit.sv
// ----------------------------------------------------------------------------
// phase_shift_depth_step_unit
// Phase-shift depth extrapolation of one wavenumber sample per word: CORDIC
// rotation for propagating bins, exponential decay for evanescent bins.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the output is not stalled; the depth
//   comes from the 32-stage square root, the 26-stage phase reduction and
//   the 12-term decay series
// a stalled output word holds the whole pipeline in place
// reset clears the configuration registers and all valid bits; no clearing pass
`default_nettype none
module phase_shift_depth_step_unit import psds_pkg::*; #(
  parameter int CORDIC_STAGES = 20
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // bin_index[9:0], samp_re[33:10], samp_im[57:34], acc_re[81:58],
  // acc_im[105:82], accumulate[106], zero fill
  input  wire logic [111:0] s_axis_tdata,
  // kind[0]
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_re[23:0], out_im[47:24]
  output logic [47:0]       m_axis_tdata,
  // saturated[0]
  output logic              m_axis_tuser
);

  localparam int SQ_N     = 32;
  localparam int RD_N     = 26;
  localparam int HORN_N   = 3 * EXP_TERMS;
  localparam int HORN_LEN = HORN_N + 1;
  localparam int CORD_LEN = CORDIC_STAGES + 1;
  localparam int NB       = (HORN_LEN > CORD_LEN) ? HORN_LEN : CORD_LEN;
  localparam int ST_CMP   = 3;
  localparam int SQ0      = 4;
  localparam int ST_PH    = SQ0 + SQ_N;
  localparam int RD0      = ST_PH + 1;
  localparam int BR0      = RD0 + RD_N;
  localparam int ST_MUL   = BR0 + NB;
  localparam int ST_RND   = ST_MUL + 1;
  localparam int ST_OUT   = ST_RND + 1;
  localparam int DEPTH    = ST_OUT + 1;
  localparam int VW       = 34;
  localparam int ZW       = 28;
  localparam int SB       = SAMPLE_BITS;

  localparam logic signed [ZW-1:0] Z_PI      = ZW'(PI_Q24);
  localparam logic signed [ZW-1:0] Z_TWO_PI  = ZW'(TWO_PI_Q24);
  localparam logic signed [ZW-1:0] Z_HALF_PI = ZW'(HALF_PI_Q24);
  localparam logic signed [SB-1:0] S_MAX     = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN     = {1'b1, {(SB-1){1'b0}}};
  localparam logic [30:0]          P_ONE     = 31'(ONE_Q30);

  // ---------------------------------------------------------------- config
  logic [31:0] freq_q, slow_q;
  logic [19:0] dz_q;
  logic [23:0] dk_q;
  logic [31:0] ws_q;
  logic [63:0] ws2_q;
  logic [63:0] ws_prod;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= '0;
      slow_q <= '0;
      dz_q   <= '0;
      dk_q   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_addr_e'(paddr[3:2]))
        REG_ANG_FREQ: freq_q <= pwdata;
        REG_SLOWNESS: slow_q <= pwdata;
        REG_DEPTH:    dz_q   <= pwdata[19:0];
        REG_WAVENUM:  dk_q   <= pwdata[23:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_addr_e'(paddr[3:2]))
      REG_ANG_FREQ: prdata = freq_q;
      REG_SLOWNESS: prdata = slow_q;
      REG_DEPTH:    prdata = {12'b0, dz_q};
      REG_WAVENUM:  prdata = {8'b0, dk_q};
      default:      prdata = '0;
    endcase
  end

  // (w*s)^2 only follows the registers, so it is worked out once
  assign ws_prod = 64'(freq_q) * 64'(slow_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q  <= '0;
      ws2_q <= '0;
    end else begin
      ws_q  <= ws_prod[63:32];
      ws2_q <= 64'(ws_q) * 64'(ws_q);
    end
  end

  // ---------------------------------------------------------- flow control
  logic [DEPTH-1:0] vld_q;
  logic             adv;

  assign adv           = !vld_q[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------- side fields
  side_t side_q [DEPTH];
  logic  prop_d;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0].kind    <= s_axis_tuser;
      side_q[0].prop    <= 1'b0;
      side_q[0].accum   <= s_axis_tdata[106];
      side_q[0].samp_re <= s_axis_tdata[33:10];
      side_q[0].samp_im <= s_axis_tdata[57:34];
      side_q[0].acc_re  <= s_axis_tdata[81:58];
      side_q[0].acc_im  <= s_axis_tdata[105:82];
    end
  end

  for (genvar i = 1; i < DEPTH; i++) begin : g_side
    side_t side_d;

    always_comb begin
      side_d = side_q[i-1];
      if (i == ST_CMP) begin
        side_d.prop = prop_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[i] <= side_d;
      end
    end
  end

  // ------------------------------------------------- wavenumber and a = ..
  logic [BIN_BITS-1:0] in_bin, m_d, m_q;
  logic [BIN_BITS:0]   bin_neg;
  logic [33:0]         mk;
  logic [25:0]         kk_q;
  logic [51:0]         k2_q;
  logic [63:0]         k2_ext, diff_q;

  assign in_bin  = s_axis_tdata[9:0];
  assign bin_neg = (BIN_BITS+1)'(FFT_SIZE) - {1'b0, in_bin};
  assign m_d     = ({1'b0, in_bin} <= bin_neg) ? in_bin : bin_neg[BIN_BITS-1:0];
  assign mk      = 34'(m_q) * 34'(dk_q);
  assign k2_ext  = {12'b0, k2_q};
  assign prop_d  = ws2_q >= k2_ext;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q    <= m_d;
      kk_q   <= mk[33:8];
      k2_q   <= 52'(kk_q) * 52'(kk_q);
      diff_q <= prop_d ? ws2_q - k2_ext : k2_ext - ws2_q;
    end
  end

  // ------------------------------------------- square root, a digit a stage
  logic [63:0] sq_rad_q  [SQ_N];
  logic [33:0] sq_rem_q  [SQ_N];
  logic [31:0] sq_root_q [SQ_N];

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    logic [63:0] rad_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] trial, test;

    if (j == 0) begin : g_first
      assign rad_in  = diff_q;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = sq_rad_q[j-1];
      assign rem_in  = sq_rem_q[j-1];
      assign root_in = sq_root_q[j-1];
    end

    assign trial = {rem_in, rad_in[63:62]};
    assign test  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rad_q[j] <= {rad_in[61:0], 2'b00};
        if (trial >= test) begin
          sq_rem_q[j]  <= 34'(trial - test);
          sq_root_q[j] <= {root_in[30:0], 1'b1};
        end else begin
          sq_rem_q[j]  <= trial[33:0];
          sq_root_q[j] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  // --------------------------------------------------------- phase dz*q
  logic [51:0] xph_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xph_q <= 52'(dz_q) * 52'(sq_root_q[SQ_N-1]);
    end
  end

  // --------------- reduction: mod 2*pi, and split by ln2 for the decay
  logic [51:0]            rd_q [RD_N];
  logic [28:0]            dr_q [RD_N];
  logic [DECAY_NBITS-1:0] dn_q [RD_N];
  logic                   dge_q [RD_N];

  for (genvar j = 0; j < RD_N; j++) begin : g_red
    localparam logic [51:0] MOD_C = 52'(TWO_PI_Q24) << (RD_N - 1 - j);
    logic [51:0]            val_in;
    logic [28:0]            dr_in;
    logic [DECAY_NBITS-1:0] dn_in;
    logic                   dge_in;

    if (j == 0) begin : g_first
      assign val_in = xph_q;
      assign dr_in  = xph_q[28:0];
      assign dn_in  = '0;
      assign dge_in = xph_q >= 52'(DECAY_SHIFTS * LN2_Q24);
    end else begin : g_next
      assign val_in = rd_q[j-1];
      assign dr_in  = dr_q[j-1];
      assign dn_in  = dn_q[j-1];
      assign dge_in = dge_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rd_q[j]  <= (val_in >= MOD_C) ? val_in - MOD_C : val_in;
        dge_q[j] <= dge_in;
      end
    end

    if (j < DECAY_NBITS) begin : g_ln2
      localparam logic [28:0] LN_C = 29'(LN2_Q24) << (DECAY_NBITS - 1 - j);
      logic bit_d;
      assign bit_d = dr_in >= LN_C;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dr_q[j] <= bit_d ? dr_in - LN_C : dr_in;
          dn_q[j] <= {dn_in[DECAY_NBITS-2:0], bit_d};
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dr_q[j] <= dr_in;
          dn_q[j] <= dn_in;
        end
      end
    end
  end

  // --------------------- branch: CORDIC rotation beside the decay series
  logic signed [VW-1:0]   cx_q [NB];
  logic signed [VW-1:0]   cy_q [NB];
  logic signed [ZW-1:0]   cz_q [NB];
  logic [30:0]            hp_q [NB];
  logic [64:0]            hw_q [NB];
  logic [29:0]            hr_q [NB];
  logic [DECAY_NBITS-1:0] hn_q [NB];
  logic                   hg_q [NB];

  for (genvar i = 0; i < NB; i++) begin : g_br
    // rotation chain
    if (i == 0) begin : g_fold
      side_t               sd;
      logic signed [ZW-1:0] z_a, z_b, z_c;
      logic signed [VW-1:0] x_a, y_a;
      logic                 flip;

      assign sd = side_q[BR0-1];

      always_comb begin
        z_a = sd.kind ? signed'(ZW'(rd_q[RD_N-1][26:0]))
                      : -signed'(ZW'(rd_q[RD_N-1][26:0]));
        if (z_a > Z_PI) begin
          z_b = z_a - Z_TWO_PI;
        end else if (z_a < -Z_PI) begin
          z_b = z_a + Z_TWO_PI;
        end else begin
          z_b = z_a;
        end
        flip = 1'b0;
        z_c  = z_b;
        if (z_b > Z_HALF_PI) begin
          flip = 1'b1;
          z_c  = z_b - Z_PI;
        end else if (z_b < -Z_HALF_PI) begin
          flip = 1'b1;
          z_c  = z_b + Z_PI;
        end
        x_a = VW'(sd.samp_re) <<< GUARD_BITS;
        y_a = VW'(sd.samp_im) <<< GUARD_BITS;
      end

      always_ff @(posedge clk_i) begin
        if (adv) begin
          cx_q[i] <= flip ? -x_a : x_a;
          cy_q[i] <= flip ? -y_a : y_a;
          cz_q[i] <= z_c;
        end
      end
    end else if (i <= CORDIC_STAGES) begin : g_rot
      localparam int                   K      = i - 1;
      localparam logic signed [ZW-1:0] Z_ATAN = ZW'(ATAN_Q24[K]);
      logic signed [VW-1:0] dx, dy;

      assign dx = cy_q[i-1] >>> K;
      assign dy = cx_q[i-1] >>> K;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (cz_q[i-1] >= 0) begin
            cx_q[i] <= cx_q[i-1] - dx;
            cy_q[i] <= cy_q[i-1] + dy;
            cz_q[i] <= cz_q[i-1] - Z_ATAN;
          end else begin
            cx_q[i] <= cx_q[i-1] + dx;
            cy_q[i] <= cy_q[i-1] - dy;
            cz_q[i] <= cz_q[i-1] + Z_ATAN;
          end
        end
      end
    end else begin : g_rot_pad
      always_ff @(posedge clk_i) begin
        if (adv) begin
          cx_q[i] <= cx_q[i-1];
          cy_q[i] <= cy_q[i-1];
          cz_q[i] <= cz_q[i-1];
        end
      end
    end

    // decay chain: three stages per series term
    logic [30:0]            p_in;
    logic [64:0]            w_in;
    logic [29:0]            r_in;
    logic [DECAY_NBITS-1:0] n_in;
    logic                   g_in;

    if (i == 0) begin : g_hfirst
      assign p_in = P_ONE;
      assign w_in = '0;
      assign r_in = {dr_q[RD_N-1][23:0], 6'b0};
      assign n_in = dn_q[RD_N-1];
      assign g_in = dge_q[RD_N-1];
    end else begin : g_hnext
      assign p_in = hp_q[i-1];
      assign w_in = hw_q[i-1];
      assign r_in = hr_q[i-1];
      assign n_in = hn_q[i-1];
      assign g_in = hg_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        hr_q[i] <= r_in;
        hn_q[i] <= n_in;
        hg_q[i] <= g_in;
      end
    end

    if (i < HORN_N && i % 3 == 0) begin : g_hmul
      always_ff @(posedge clk_i) begin
        if (adv) begin
          hw_q[i] <= 65'(r_in) * 65'(p_in);
          hp_q[i] <= p_in;
        end
      end
    end else if (i < HORN_N && i % 3 == 1) begin : g_hrcp
      // floor(t/k) as t * ceil(2^34/k) >> 34, exact for t below 2^30
      localparam int          KT  = EXP_TERMS - i / 3;
      localparam logic [34:0] RCP = 35'(((64'd1 << 34) + 64'(KT) - 64'd1) / 64'(KT));
      always_ff @(posedge clk_i) begin
        if (adv) begin
          hw_q[i] <= 65'(w_in[59:30]) * 65'(RCP);
          hp_q[i] <= p_in;
        end
      end
    end else if (i < HORN_N) begin : g_hsub
      always_ff @(posedge clk_i) begin
        if (adv) begin
          hw_q[i] <= w_in;
          hp_q[i] <= P_ONE - 31'(w_in[63:34]);
        end
      end
    end else if (i == HORN_N) begin : g_hshift
      always_ff @(posedge clk_i) begin
        if (adv) begin
          hw_q[i] <= w_in;
          hp_q[i] <= g_in ? '0 : p_in >> n_in;
        end
      end
    end else begin : g_hpad
      always_ff @(posedge clk_i) begin
        if (adv) begin
          hw_q[i] <= w_in;
          hp_q[i] <= p_in;
        end
      end
    end
  end

  // -------------------------------------------- gain, rounding, clipping
  side_t                sm, sr, so;
  logic [VW-1:0]        ax, ay;
  logic [32:0]          mag_re, mag_im;
  logic [30:0]          factor;
  logic [63:0]          pr_re_q, pr_im_q, rnd_re, rnd_im;
  logic                 neg_re_q, neg_im_q;
  logic signed [26:0]   res_re_q, res_im_q;
  logic signed [27:0]   sum_re, sum_im;
  logic signed [SB-1:0] out_re_q, out_im_q, clip_re, clip_im;
  logic                 sat_q, sat_re, sat_im;

  assign sm = side_q[ST_MUL-1];
  assign sr = side_q[ST_RND-1];
  assign so = side_q[ST_OUT-1];

  // widen before negating so that the most negative sample keeps its magnitude
  assign ax     = cx_q[NB-1][VW-1] ? -cx_q[NB-1] : cx_q[NB-1];
  assign ay     = cy_q[NB-1][VW-1] ? -cy_q[NB-1] : cy_q[NB-1];
  assign mag_re = sm.prop ? ax[32:0]
                          : (sm.samp_re[SB-1] ? -(33'(sm.samp_re)) : 33'(sm.samp_re));
  assign mag_im = sm.prop ? ay[32:0]
                          : (sm.samp_im[SB-1] ? -(33'(sm.samp_im)) : 33'(sm.samp_im));
  assign factor = sm.prop ? 31'(CORDIC_GAIN_Q24) : hp_q[NB-1];

  assign rnd_re = pr_re_q + (64'd1 << 29);
  assign rnd_im = pr_im_q + (64'd1 << 29);

  assign sum_re = 28'(res_re_q) + (so.accum ? 28'(so.acc_re) : 28'sd0);
  assign sum_im = 28'(res_im_q) + (so.accum ? 28'(so.acc_im) : 28'sd0);

  always_comb begin
    sat_re  = 1'b0;
    sat_im  = 1'b0;
    clip_re = sum_re[SB-1:0];
    clip_im = sum_im[SB-1:0];
    if (sum_re > 28'(S_MAX)) begin
      sat_re  = 1'b1;
      clip_re = S_MAX;
    end else if (sum_re < 28'(S_MIN)) begin
      sat_re  = 1'b1;
      clip_re = S_MIN;
    end
    if (sum_im > 28'(S_MAX)) begin
      sat_im  = 1'b1;
      clip_im = S_MAX;
    end else if (sum_im < 28'(S_MIN)) begin
      sat_im  = 1'b1;
      clip_im = S_MIN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_re_q  <= 64'(mag_re) * 64'(factor);
      pr_im_q  <= 64'(mag_im) * 64'(factor);
      neg_re_q <= sm.prop ? cx_q[NB-1][VW-1] : sm.samp_re[SB-1];
      neg_im_q <= sm.prop ? cy_q[NB-1][VW-1] : sm.samp_im[SB-1];
      // round half away from zero on the magnitude
      res_re_q <= neg_re_q ? -signed'({1'b0, rnd_re[55:30]})
                           :  signed'({1'b0, rnd_re[55:30]});
      res_im_q <= neg_im_q ? -signed'({1'b0, rnd_im[55:30]})
                           :  signed'({1'b0, rnd_im[55:30]});
      out_re_q <= clip_re;
      out_im_q <= clip_im;
      sat_q    <= sat_re || sat_im;
    end
  end

  assign m_axis_tdata = {out_im_q, out_re_q};
  assign m_axis_tuser = sat_q;

  // ------------------------------------------------------------ checks
  a_sat_extreme : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (out_re_q == S_MAX || out_re_q == S_MIN ||
       out_im_q == S_MAX || out_im_q == S_MIN))
    else $error("saturated word without a clipped part");

  a_sqrt_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SQ0+SQ_N-1] |-> sq_rem_q[SQ_N-1] <= {1'b0, sq_root_q[SQ_N-1], 1'b0})
    else $error("square root remainder out of range");

  a_phase_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[BR0-1] |-> rd_q[RD_N-1] < 52'(TWO_PI_Q24))
    else $error("phase not reduced below two pi");

  a_decay_gain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[BR0+NB-1] |-> hp_q[NB-1] <= P_ONE)
    else $error("decay gain above one");

endmodule
`default_nettype wire

FILE: verif/tb_phase_shift_depth_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phase_shift_depth_step_unit
// Self-checking bench for the phase-shift depth step unit. A directed table
// covers register extremes, saturation and full decay. Random phases follow
// with new register settings, random idling on both streams, a long output
// stall and a full drain. Each output word is checked against a bit-true
// predictor of the rotation and decay arithmetic, or against a typed row's result.
// ----------------------------------------------------------------------------
module tb_phase_shift_depth_step_unit;
  import psds_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 150;
  localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S_MIN = -24'sh800000;

  typedef struct packed {
    logic                     kind;
    logic [BIN_BITS-1:0]      bin;
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic signed [SAMPLE_BITS-1:0] acc_re;
    logic signed [SAMPLE_BITS-1:0] acc_im;
    logic                     accum;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          sat;
  } out_word_t;

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t res;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         psel, penable, pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;

  // register copies
  logic [31:0] ang_freq, slow;
  logic [19:0] dz;
  logic [23:0] dk;

  out_word_t pending_out[$];
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  int  hold_left = 0;
  int  gap_left = 0;
  row_t dir_rows[20];

  phase_shift_depth_step_unit i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_scale(longint v, longint unsigned g, int sh);
    longint unsigned mag, r;
    mag = v < 0 ? -v : v;
    r = (mag * g + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned decay_gain(longint unsigned x);
    longint unsigned n, r30, p;
    n = x / LN2_Q24;
    r30 = (x - n * LN2_Q24) << 6;
    p = ONE_Q30;
    if (n >= 32) return 0;
    for (int k = EXP_TERMS; k >= 1; k--) p = ONE_Q30 - ((r30 * p) >> 30) / k;
    return p >> n;
  endfunction

  function automatic longint clip24(longint v, inout logic sat);
    if (v > S_MAX) begin sat = 1'b1; return S_MAX; end
    if (v < S_MIN) begin sat = 1'b1; return S_MIN; end
    return v;
  endfunction

  function automatic out_word_t extrapolate_word(in_word_t w);
    longint unsigned m, ws, kk, ws2, k2, ph, g;
    longint re, im, x, y, z, dx, dy;
    logic sat;
    out_word_t o;
    m = w.bin <= FFT_SIZE - w.bin ? w.bin : FFT_SIZE - w.bin;
    ws = (64'(ang_freq) * 64'(slow)) >> 32;
    kk = (m * 64'(dk)) >> 8;
    ws2 = ws * ws;
    k2 = kk * kk;
    re = w.re;
    im = w.im;
    sat = 1'b0;
    if (ws2 >= k2) begin
      ph = (64'(dz) * isqrt(ws2 - k2)) % TWO_PI_Q24;
      z = w.kind ? longint'(ph) : -longint'(ph);
      x = re <<< GUARD_BITS;
      y = im <<< GUARD_BITS;
      if (z > PI_Q24) z -= TWO_PI_Q24;
      if (z < -PI_Q24) z += TWO_PI_Q24;
      if (z > HALF_PI_Q24) begin x = -x; y = -y; z -= PI_Q24; end
      if (z < -HALF_PI_Q24) begin x = -x; y = -y; z += PI_Q24; end
      for (int i = 0; i < 20; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin x -= dx; y += dy; z -= ATAN_Q24[i]; end
        else begin x += dx; y -= dy; z += ATAN_Q24[i]; end
      end
      re = round_scale(x, CORDIC_GAIN_Q24, 24 + GUARD_BITS);
      im = round_scale(y, CORDIC_GAIN_Q24, 24 + GUARD_BITS);
    end else begin
      g = decay_gain(64'(dz) * isqrt(k2 - ws2));
      re = round_scale(re, g, 30);
      im = round_scale(im, g, 30);
    end
    if (w.accum) begin
      re += w.acc_re;
      im += w.acc_im;
    end
    o.re = SAMPLE_BITS'(clip24(re, sat));
    o.im = SAMPLE_BITS'(clip24(im, sat));
    o.sat = sat;
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  task automatic reg_write(reg_addr_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_ANG_FREQ: ang_freq = val;
      REG_SLOWNESS: slow = val;
      REG_DEPTH:    dz = val[19:0];
      REG_WAVENUM:  dk = val[23:0];
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] f, logic [31:0] s, logic [31:0] d, logic [31:0] k);
    reg_write(REG_ANG_FREQ, f);
    reg_write(REG_SLOWNESS, s);
    reg_write(REG_DEPTH, d);
    reg_write(REG_WAVENUM, k);
  endtask

  task automatic drain(int cycles);
    while (pending_out.size() > 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  // typed set means the row carries its own result instead of the predictor's
  task automatic send_word(in_word_t w, logic typed, out_word_t res);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= w.kind;
    s_axis_tdata <= {5'd0, w.accum, w.acc_im, w.acc_re, w.im, w.re, w.bin};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_out.push_back(typed ? res : extrapolate_word(w));
  endtask

  function automatic logic [23:0] rand_samp();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return 24'd0;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.kind = 1'($urandom);
    w.bin = BIN_BITS'($urandom);
    w.re = rand_samp();
    w.im = rand_samp();
    w.acc_re = rand_samp();
    w.acc_im = rand_samp();
    w.accum = 1'($urandom);
    return w;
  endfunction

  // output side: random bursts of stall, one long hold on request
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      gap_left <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_out.size() == 0) begin
        report("unexpected word", longint'(m_axis_tdata), 0);
      end else begin
        want = pending_out.pop_front();
        if (m_axis_tdata[23:0] !== want.re) report("out_re", $signed(m_axis_tdata[23:0]), want.re);
        if (m_axis_tdata[47:24] !== want.im)
          report("out_im", $signed(m_axis_tdata[47:24]), want.im);
        if (m_axis_tuser !== want.sat) report("saturated", m_axis_tuser, want.sat);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    out_word_t none;
    none = '0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    ang_freq = 0;
    slow = 0;
    dz = 0;
    dk = 0;

    // registers at reset: zero phase, only the clipped row is typed
    dir_rows[0] = '{'{0, 10'd0, S_MAX, S_MIN, S_MAX, S_MIN, 1}, 1, '{S_MAX, S_MIN, 1}};
    dir_rows[1] = '{'{0, 10'd0, 24'd0, 24'd0, 24'd0, 24'd0, 0}, 0, none};
    dir_rows[2] = '{'{1, 10'd1023, S_MAX, S_MAX, 24'd0, 24'd0, 0}, 0, none};
    dir_rows[3] = '{'{0, 10'd512, S_MIN, S_MIN, S_MIN, S_MIN, 1}, 0, none};
    dir_rows[4] = '{'{1, 10'd511, 24'd12345, -24'sd777, 24'd5, 24'd9, 1}, 0, none};
    // full decay: freq 0, dz and dk at maximum
    dir_rows[5] = '{'{0, 10'd512, S_MAX, S_MIN, 24'd100, -24'sd100, 1}, 1,
                    '{24'd100, -24'sd100, 0}};
    dir_rows[6] = '{'{1, 10'd1, S_MAX, S_MAX, S_MAX, S_MAX, 0}, 1, '{24'd0, 24'd0, 0}};
    dir_rows[7] = '{'{0, 10'd1023, S_MIN, S_MAX, S_MIN, S_MAX, 1}, 1,
                    '{S_MIN, S_MAX, 0}};
    dir_rows[8] = '{'{1, 10'd0, S_MAX, S_MIN, 24'd0, 24'd0, 0}, 0, none};
    dir_rows[9] = '{'{0, 10'd0, 24'd1, -24'sd1, 24'd0, 24'd0, 1}, 0, none};
    // all registers at maximum
    for (int i = 10; i < 20; i++) begin
      dir_rows[i].w = rand_word();
      dir_rows[i].w.kind = i[0];
      dir_rows[i].typed = 0;
      dir_rows[i].res = none;
    end
    dir_rows[10].w.bin = 10'd0;
    dir_rows[11].w.bin = 10'd512;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 20; i++) begin
      if (i == 5 || i == 10) begin
        s_axis_tvalid <= 1'b0;
        drain(120);
        if (i == 5) set_regs(32'd0, 32'hFFFF_FFFF, 32'h000F_FFFF, 32'h00FF_FFFF);
        else set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      end
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int ph = 0; ph < 8; ph++) begin
      s_axis_tvalid <= 1'b0;
      drain(120);
      set_regs($urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 31),
               $urandom >> $urandom_range(0, 24), $urandom >> $urandom_range(0, 24));
      if (ph == 3) hold_req = 1;
      if (ph == 7) no_idle = 1;
      for (int n = 0; n < 80; n++) begin
        if (ph == 5 && n == 40) begin
          s_axis_tvalid <= 1'b0;
          while (pending_out.size() > 0) @(posedge clk_i);
        end
        send_word(rand_word(), 0, none);
      end
    end
    s_axis_tvalid <= 1'b0;
    drain(DRAIN_CYCLES);

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
